// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Each one clocks on clk and stays quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define QOA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define QOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/qoa_pkg.sv
`timescale 1ns / 1ps
package qoa_pkg;

  // Fixed-point format of quaternion components and matrix entries
  localparam int FRAC_BITS  = 14;
  localparam int QUAT_WIDTH = 16;

  // Exact product, and an accumulator that holds four products plus rounding
  localparam int PROD_W = 2 * QUAT_WIDTH;
  localparam int ACC_W  = 2 * QUAT_WIDTH + 3;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [QUAT_WIDTH-1:0] comp_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [ACC_W-1:0]      acc_t;

  typedef enum logic {
    OP_ROTATE = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
  } quat_t;

  typedef struct packed {
    op_t   op;
    quat_t q;
  } req_t;

  // Head of the request queue as seen by the back end
  typedef struct packed {
    logic valid;
    req_t req;
  } head_t;

  typedef struct packed {
    comp_t r0_c0;
    comp_t r0_c1;
    comp_t r0_c2;
    comp_t r1_c0;
    comp_t r1_c1;
    comp_t r1_c2;
    comp_t r2_c0;
    comp_t r2_c1;
    comp_t r2_c2;
  } mat_t;

  localparam comp_t COMP_MAX = {1'b0, {(QUAT_WIDTH - 1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(QUAT_WIDTH - 1){1'b0}}};

  // One in component format, clamped when the format cannot hold it
  localparam comp_t ONE_Q =
    (FRAC_BITS >= QUAT_WIDTH - 1) ? COMP_MAX : (comp_t'(1) << FRAC_BITS);

  localparam acc_t SMAX_ACC = acc_t'(COMP_MAX);
  localparam acc_t SMIN_ACC = acc_t'(COMP_MIN);
  localparam acc_t HALF_ACC = acc_t'(1) << (FRAC_BITS - 1);
  // One at the product scale, i.e. 2*FRAC_BITS fraction bits
  localparam acc_t ONE_ACC  = acc_t'(1) << (2 * FRAC_BITS);

  function automatic prod_t mul(input comp_t a, input comp_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  function automatic acc_t ext(input prod_t p);
    return acc_t'(p);
  endfunction

  // Round half up to FRAC_BITS fraction bits, then clamp to the component range
  function automatic comp_t round_sat(input acc_t acc);
    acc_t rounded;
    acc_t shifted;
    rounded = acc + HALF_ACC;
    shifted = rounded >>> FRAC_BITS;
    if (shifted > SMAX_ACC) begin
      return COMP_MAX;
    end else if (shifted < SMIN_ACC) begin
      return COMP_MIN;
    end else begin
      return $signed(shifted[QUAT_WIDTH-1:0]);
    end
  endfunction

endpackage

// File: rtl/qoa_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qoa_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                req_type,
  input  qoa_pkg::quat_t      quat,
  input  logic                pop,
  output qoa_pkg::head_t      head
);
  import qoa_pkg::*;

  req_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  req_t              req_in;

  // Classify the incoming request: only bit 0 of the type matters
  always_comb begin
    req_in.op = (req_type == 1'b1) ? OP_LOAD : OP_ROTATE;
    req_in.q  = quat;
  end

  assign req_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign push      = req_valid && !req_stall;

  assign head.valid = (count != '0);
  assign head.req   = entries[rd_ptr];

  // Hold queued requests
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= req_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  `QOA_ASSERT(a_no_pop_empty, !(pop && !head.valid), "pop from empty request queue")
  `QOA_ASSERT_NEXT(a_fill, push && !pop, count == $past(count) + QCNT_W'(1), "queue fill lost")
  `QOA_ASSERT_NEXT(a_drain, pop && !push, count == $past(count) - QCNT_W'(1), "queue drain lost")

endmodule

// File: rtl/qoa_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qoa_back (
  input  logic           clk,
  input  logic           rst,
  input  qoa_pkg::head_t head,
  output logic           pop,
  output qoa_pkg::mat_t  mat,
  output logic           mat_valid,
  input  logic           mat_stall
);
  import qoa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QSUM,
    ST_MPROD,
    ST_MSUM
  } state_t;

  state_t st;
  quat_t  orient;
  prod_t  hp [16];
  prod_t  mp [9];
  quat_t  orient_next;
  mat_t   mat_next;
  acc_t   macc [9];
  quat_t  a;
  logic   mat_load;

  assign a   = head.req.q;
  assign pop = (st == ST_IDLE) && head.valid;

  // Load the output register once the previous matrix has gone or is going
  assign mat_load = (st == ST_MSUM) && (!mat_valid || !mat_stall);

  // Sum the Hamilton products into the new orientation
  always_comb begin
    orient_next.x = round_sat(ext(hp[0]) + ext(hp[1]) + ext(hp[2]) - ext(hp[3]));
    orient_next.y = round_sat(ext(hp[4]) + ext(hp[5]) + ext(hp[6]) - ext(hp[7]));
    orient_next.z = round_sat(ext(hp[8]) + ext(hp[9]) + ext(hp[10]) - ext(hp[11]));
    orient_next.w = round_sat(ext(hp[12]) - ext(hp[13]) - ext(hp[14]) - ext(hp[15]));
  end

  // Form the matrix entries; products are xx yy zz xy xz yz wx wy wz
  always_comb begin
    macc[0] = ONE_ACC - ((ext(mp[1]) + ext(mp[2])) <<< 1);
    macc[1] = (ext(mp[3]) - ext(mp[8])) <<< 1;
    macc[2] = (ext(mp[4]) + ext(mp[7])) <<< 1;
    macc[3] = (ext(mp[3]) + ext(mp[8])) <<< 1;
    macc[4] = ONE_ACC - ((ext(mp[0]) + ext(mp[2])) <<< 1);
    macc[5] = (ext(mp[5]) - ext(mp[6])) <<< 1;
    macc[6] = (ext(mp[4]) - ext(mp[7])) <<< 1;
    macc[7] = (ext(mp[5]) + ext(mp[6])) <<< 1;
    macc[8] = ONE_ACC - ((ext(mp[0]) + ext(mp[1])) <<< 1);
    mat_next.r0_c0 = round_sat(macc[0]);
    mat_next.r0_c1 = round_sat(macc[1]);
    mat_next.r0_c2 = round_sat(macc[2]);
    mat_next.r1_c0 = round_sat(macc[3]);
    mat_next.r1_c1 = round_sat(macc[4]);
    mat_next.r1_c2 = round_sat(macc[5]);
    mat_next.r2_c0 = round_sat(macc[6]);
    mat_next.r2_c1 = round_sat(macc[7]);
    mat_next.r2_c2 = round_sat(macc[8]);
  end

  // Sequence one request: products and sum (rotate only), matrix products, matrix out
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      mat_valid <= 1'b0;
      orient    <= '{x: '0, y: '0, z: '0, w: ONE_Q};
    end else begin
      mat_valid <= mat_load || (mat_valid && mat_stall);
      case (st)
        ST_IDLE: begin
          if (head.valid) begin
            if (head.req.op == OP_LOAD) begin
              orient <= a;
              st     <= ST_MPROD;
            end else begin
              hp[0]  <= mul(a.w, orient.x);
              hp[1]  <= mul(a.x, orient.w);
              hp[2]  <= mul(a.y, orient.z);
              hp[3]  <= mul(a.z, orient.y);
              hp[4]  <= mul(a.w, orient.y);
              hp[5]  <= mul(a.y, orient.w);
              hp[6]  <= mul(a.z, orient.x);
              hp[7]  <= mul(a.x, orient.z);
              hp[8]  <= mul(a.w, orient.z);
              hp[9]  <= mul(a.z, orient.w);
              hp[10] <= mul(a.x, orient.y);
              hp[11] <= mul(a.y, orient.x);
              hp[12] <= mul(a.w, orient.w);
              hp[13] <= mul(a.x, orient.x);
              hp[14] <= mul(a.y, orient.y);
              hp[15] <= mul(a.z, orient.z);
              st     <= ST_QSUM;
            end
          end
        end
        ST_QSUM: begin
          orient <= orient_next;
          st     <= ST_MPROD;
        end
        ST_MPROD: begin
          mp[0] <= mul(orient.x, orient.x);
          mp[1] <= mul(orient.y, orient.y);
          mp[2] <= mul(orient.z, orient.z);
          mp[3] <= mul(orient.x, orient.y);
          mp[4] <= mul(orient.x, orient.z);
          mp[5] <= mul(orient.y, orient.z);
          mp[6] <= mul(orient.w, orient.x);
          mp[7] <= mul(orient.w, orient.y);
          mp[8] <= mul(orient.w, orient.z);
          st    <= ST_MSUM;
        end
        ST_MSUM: begin
          if (mat_load) begin
            mat <= mat_next;
            st  <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  `QOA_ASSERT_NEXT(a_load_state, pop && head.req.op == OP_LOAD, orient == $past(a), "load lost")
  `QOA_ASSERT_NEXT(a_state_hold, !pop && st != ST_QSUM, $stable(orient), "orientation moved")
  `QOA_ASSERT(a_qsum_entry, st != ST_QSUM || $past(pop), "product sum without a request")

endmodule

// File: rtl/quaternion_orientation_accumulator_core.sv
`timescale 1ns / 1ps
// Quaternion orientation accumulator. Holds one orientation quaternion in signed
// Q2.14 that resets to identity. Each request either loads a new quaternion
// (req_type 1) or rotates the held one by the request quaternion on the left
// (req_type 0); every request yields the 3x3 rotation matrix of the new
// orientation, with all values rounded half up and saturated. No normalisation
// is done. Requests enter a two-entry queue; the execution side takes one at a
// time: a rotate registers the quaternion products and sums them into the
// orientation, a load writes it directly; both then register the matrix
// products and sum them into the output register. The matrix sits there, so
// the next request starts while it waits to be taken.
module quaternion_orientation_accumulator_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic                                  req_type,
  input  logic signed [qoa_pkg::QUAT_WIDTH-1:0] quat_x,
  input  logic signed [qoa_pkg::QUAT_WIDTH-1:0] quat_y,
  input  logic signed [qoa_pkg::QUAT_WIDTH-1:0] quat_z,
  input  logic signed [qoa_pkg::QUAT_WIDTH-1:0] quat_w,
  output logic                                  mat_valid,
  input  logic                                  mat_stall,
  output logic signed [qoa_pkg::QUAT_WIDTH-1:0] m_r0_c0,
  output logic signed [qoa_pkg::QUAT_WIDTH-1:0] m_r0_c1,
  output logic signed [qoa_pkg::QUAT_WIDTH-1:0] m_r0_c2,
  output logic signed [qoa_pkg::QUAT_WIDTH-1:0] m_r1_c0,
  output logic signed [qoa_pkg::QUAT_WIDTH-1:0] m_r1_c1,
  output logic signed [qoa_pkg::QUAT_WIDTH-1:0] m_r1_c2,
  output logic signed [qoa_pkg::QUAT_WIDTH-1:0] m_r2_c0,
  output logic signed [qoa_pkg::QUAT_WIDTH-1:0] m_r2_c1,
  output logic signed [qoa_pkg::QUAT_WIDTH-1:0] m_r2_c2
);
  import qoa_pkg::*;

  quat_t quat;
  head_t head;
  logic  pop;
  mat_t  mat;

  assign quat = '{x: quat_x, y: quat_y, z: quat_z, w: quat_w};

  // Accept and queue requests
  qoa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .quat      (quat),
    .pop       (pop),
    .head      (head)
  );

  // Execute requests and hold the matrix
  qoa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .mat       (mat),
    .mat_valid (mat_valid),
    .mat_stall (mat_stall)
  );

  assign m_r0_c0 = mat.r0_c0;
  assign m_r0_c1 = mat.r0_c1;
  assign m_r0_c2 = mat.r0_c2;
  assign m_r1_c0 = mat.r1_c0;
  assign m_r1_c1 = mat.r1_c1;
  assign m_r1_c2 = mat.r1_c2;
  assign m_r2_c0 = mat.r2_c0;
  assign m_r2_c1 = mat.r2_c1;
  assign m_r2_c2 = mat.r2_c2;

endmodule

// File: tb/sv/qoa_orient_checker.sv
`timescale 1ns / 1ps
module qoa_orient_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  logic           req_type,
  input  qoa_pkg::comp_t quat_x,
  input  qoa_pkg::comp_t quat_y,
  input  qoa_pkg::comp_t quat_z,
  input  qoa_pkg::comp_t quat_w,
  input  logic           mat_valid,
  input  logic           mat_stall,
  input  qoa_pkg::comp_t m_r0_c0,
  input  qoa_pkg::comp_t m_r0_c1,
  input  qoa_pkg::comp_t m_r0_c2,
  input  qoa_pkg::comp_t m_r1_c0,
  input  qoa_pkg::comp_t m_r1_c1,
  input  qoa_pkg::comp_t m_r1_c2,
  input  qoa_pkg::comp_t m_r2_c0,
  input  qoa_pkg::comp_t m_r2_c1,
  input  qoa_pkg::comp_t m_r2_c2,
  output int             mismatches,
  output int             mats_due
);
  import qoa_pkg::*;

  localparam int     REPORT_LIMIT = 10;
  // Half an output LSB and one, both at the scale of an exact product
  localparam longint HALF_LSB     = longint'(1) << (FRAC_BITS - 1);
  localparam longint ONE_WIDE     = longint'(1) << (2 * FRAC_BITS);

  string entry_names [9] = '{"m_r0_c0", "m_r0_c1", "m_r0_c2",
                             "m_r1_c0", "m_r1_c1", "m_r1_c2",
                             "m_r2_c0", "m_r2_c1", "m_r2_c2"};

  quat_t orient;
  mat_t  expected_mats [$];
  int    err_count = 0;

  initial begin
    mismatches = 0;
    mats_due   = 0;
  end

  function automatic longint wide_prod(input comp_t a, input comp_t b);
    return longint'(a) * longint'(b);
  endfunction

  // Round an exact sum half up to the component format, then clamp it
  function automatic comp_t settle(input longint s);
    longint r;
    r = (s + HALF_LSB) >>> FRAC_BITS;
    if (r > longint'(COMP_MAX)) return COMP_MAX;
    if (r < longint'(COMP_MIN)) return COMP_MIN;
    return comp_t'(r);
  endfunction

  // Hamilton product with the request quaternion on the left
  function automatic quat_t compose(input quat_t a, input quat_t b);
    quat_t n;
    n.x = settle(wide_prod(a.w, b.x) + wide_prod(a.x, b.w)
               + wide_prod(a.y, b.z) - wide_prod(a.z, b.y));
    n.y = settle(wide_prod(a.w, b.y) + wide_prod(a.y, b.w)
               + wide_prod(a.z, b.x) - wide_prod(a.x, b.z));
    n.z = settle(wide_prod(a.w, b.z) + wide_prod(a.z, b.w)
               + wide_prod(a.x, b.y) - wide_prod(a.y, b.x));
    n.w = settle(wide_prod(a.w, b.w) - wide_prod(a.x, b.x)
               - wide_prod(a.y, b.y) - wide_prod(a.z, b.z));
    return n;
  endfunction

  function automatic mat_t rotation_matrix(input quat_t q);
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
    mat_t   m;
    xx = wide_prod(q.x, q.x);
    yy = wide_prod(q.y, q.y);
    zz = wide_prod(q.z, q.z);
    xy = wide_prod(q.x, q.y);
    xz = wide_prod(q.x, q.z);
    yz = wide_prod(q.y, q.z);
    wx = wide_prod(q.w, q.x);
    wy = wide_prod(q.w, q.y);
    wz = wide_prod(q.w, q.z);
    m.r0_c0 = settle(ONE_WIDE - 2 * (yy + zz));
    m.r0_c1 = settle(2 * (xy - wz));
    m.r0_c2 = settle(2 * (xz + wy));
    m.r1_c0 = settle(2 * (xy + wz));
    m.r1_c1 = settle(ONE_WIDE - 2 * (xx + zz));
    m.r1_c2 = settle(2 * (yz - wx));
    m.r2_c0 = settle(2 * (xz - wy));
    m.r2_c1 = settle(2 * (yz + wx));
    m.r2_c2 = settle(ONE_WIDE - 2 * (xx + yy));
    return m;
  endfunction

  // Track the orientation per accepted request, compare each matrix taken
  always @(posedge clk) begin
    quat_t incoming;
    mat_t  want;
    mat_t  got;
    comp_t want_c;
    comp_t got_c;
    if (rst) begin
      orient = '{x: comp_t'(0), y: comp_t'(0), z: comp_t'(0), w: ONE_Q};
      expected_mats.delete();
    end else begin
      if (req_valid && !req_stall) begin
        incoming = '{x: quat_x, y: quat_y, z: quat_z, w: quat_w};
        if (req_type == OP_LOAD) begin
          orient = incoming;
        end else begin
          orient = compose(incoming, orient);
        end
        expected_mats.push_back(rotation_matrix(orient));
      end
      if (mat_valid && !mat_stall) begin
        got = {m_r0_c0, m_r0_c1, m_r0_c2, m_r1_c0, m_r1_c1, m_r1_c2,
               m_r2_c0, m_r2_c1, m_r2_c2};
        if (expected_mats.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_LIMIT) begin
            $display("%0t: matrix with no request outstanding", $realtime);
          end
        end else begin
          want = expected_mats.pop_front();
          for (int i = 0; i < 9; i++) begin
            want_c = want[(8 - i) * QUAT_WIDTH +: QUAT_WIDTH];
            got_c  = got[(8 - i) * QUAT_WIDTH +: QUAT_WIDTH];
            if (want_c !== got_c) begin
              err_count++;
              if (err_count <= REPORT_LIMIT) begin
                $display("%0t: %s expected %0d, got %0d", $realtime,
                         entry_names[i], want_c, got_c);
              end
            end
          end
        end
      end
    end
    mismatches <= err_count;
    mats_due   <= expected_mats.size();
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import qoa_pkg::*;

  localparam int RANDOM_PER_PHASE = 350;
  localparam int HOLD_CYCLES      = 64;
  localparam int DRAIN_CYCLES     = 10;
  localparam int WATCHDOG_LIMIT   = 2000;

  logic  clk = 1'b0;
  logic  rst;
  logic  req_valid;
  logic  req_stall;
  logic  req_type;
  comp_t quat_x, quat_y, quat_z, quat_w;
  logic  mat_valid;
  logic  mat_stall;
  comp_t m_r0_c0, m_r0_c1, m_r0_c2;
  comp_t m_r1_c0, m_r1_c1, m_r1_c2;
  comp_t m_r2_c0, m_r2_c1, m_r2_c2;

  int mismatches;
  int mats_due;
  int send_idle_pct = 0;
  int rx_stall_pct  = 0;
  int hold_asked    = 0;
  int quiet_cycles  = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  quaternion_orientation_accumulator_core DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_type (req_type),
    .quat_x   (quat_x),
    .quat_y   (quat_y),
    .quat_z   (quat_z),
    .quat_w   (quat_w),
    .mat_valid(mat_valid),
    .mat_stall(mat_stall),
    .m_r0_c0  (m_r0_c0),
    .m_r0_c1  (m_r0_c1),
    .m_r0_c2  (m_r0_c2),
    .m_r1_c0  (m_r1_c0),
    .m_r1_c1  (m_r1_c1),
    .m_r1_c2  (m_r1_c2),
    .m_r2_c0  (m_r2_c0),
    .m_r2_c1  (m_r2_c1),
    .m_r2_c2  (m_r2_c2)
  );

  qoa_orient_checker orient_chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .quat_w    (quat_w),
    .mat_valid (mat_valid),
    .mat_stall (mat_stall),
    .m_r0_c0   (m_r0_c0),
    .m_r0_c1   (m_r0_c1),
    .m_r0_c2   (m_r0_c2),
    .m_r1_c0   (m_r1_c0),
    .m_r1_c1   (m_r1_c1),
    .m_r1_c2   (m_r1_c2),
    .m_r2_c0   (m_r2_c0),
    .m_r2_c1   (m_r2_c1),
    .m_r2_c2   (m_r2_c2),
    .mismatches(mismatches),
    .mats_due  (mats_due)
  );

  // Offer one request after a random idle gap, hold it until taken
  task automatic offer_request(input op_t op, input quat_t q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= op;
    quat_x    <= q.x;
    quat_y    <= q.y;
    quat_z    <= q.z;
    quat_w    <= q.w;
    do @(posedge clk); while (req_stall);
  endtask

  // Drop valid and hold off until every matrix has been taken
  task automatic wait_for_matrices();
    req_valid <= 1'b0;
    @(posedge clk);
    while (mats_due != 0) @(posedge clk);
  endtask

  // Random direction scaled to roughly unit length
  function automatic quat_t near_unit_quat();
    int    raw [4];
    real   norm;
    real   scale;
    quat_t q;
    foreach (raw[i]) raw[i] = int'($urandom_range(0, 32768)) - 16384;
    norm  = $sqrt(real'(raw[0] * raw[0] + raw[1] * raw[1]
                        + raw[2] * raw[2] + raw[3] * raw[3]));
    scale = 2.0 ** FRAC_BITS;
    if (norm < 1.0) begin
      return '{x: comp_t'(0), y: comp_t'(0), z: comp_t'(0), w: ONE_Q};
    end
    q.x = comp_t'($rtoi(raw[0] * scale / norm));
    q.y = comp_t'($rtoi(raw[1] * scale / norm));
    q.z = comp_t'($rtoi(raw[2] * scale / norm));
    q.w = comp_t'($rtoi(raw[3] * scale / norm));
    return q;
  endfunction

  // Receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    int hold_served;
    hold_served = 0;
    mat_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_served++;
        mat_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mat_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (mat_valid && !mat_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    comp_t corners [5];
    int    pick;
    quat_t q;
    op_t   op;

    corners   = '{COMP_MIN, COMP_MAX, comp_t'(0), comp_t'(-1), comp_t'(1)};
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_type  <= OP_ROTATE;
    quat_x    <= '0;
    quat_y    <= '0;
    quat_z    <= '0;
    quat_w    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identity, quarter turns, zero, extremes, overflow
    offer_request(OP_ROTATE, '{x: 16'sd0, y: 16'sd0, z: 16'sd0, w: ONE_Q});
    offer_request(OP_ROTATE, '{x: 16'sd0, y: 16'sd0, z: 16'sd11585, w: 16'sd11585});
    offer_request(OP_ROTATE, '{x: 16'sd0, y: 16'sd0, z: 16'sd11585, w: 16'sd11585});
    offer_request(OP_LOAD,   '{x: 16'sd0, y: 16'sd0, z: 16'sd0, w: 16'sd0});
    offer_request(OP_ROTATE, '{x: COMP_MAX, y: COMP_MAX, z: COMP_MAX, w: COMP_MAX});
    offer_request(OP_LOAD,   '{x: COMP_MAX, y: COMP_MAX, z: COMP_MAX, w: COMP_MAX});
    offer_request(OP_ROTATE, '{x: COMP_MAX, y: COMP_MAX, z: COMP_MAX, w: COMP_MAX});
    offer_request(OP_LOAD,   '{x: COMP_MIN, y: COMP_MIN, z: COMP_MIN, w: COMP_MIN});
    offer_request(OP_ROTATE, '{x: COMP_MIN, y: COMP_MIN, z: COMP_MIN, w: COMP_MIN});
    offer_request(OP_LOAD,   '{x: COMP_MAX, y: COMP_MIN, z: COMP_MAX, w: COMP_MIN});
    offer_request(OP_ROTATE, '{x: COMP_MIN, y: COMP_MAX, z: -16'sd1, w: 16'sd1});
    offer_request(OP_LOAD,   '{x: 16'sd1, y: 16'sd1, z: 16'sd1, w: 16'sd1});
    offer_request(OP_ROTATE, '{x: -16'sd1, y: -16'sd1, z: -16'sd1, w: -16'sd1});
    offer_request(OP_LOAD,   '{x: ONE_Q, y: 16'sd0, z: 16'sd0, w: 16'sd0});
    offer_request(OP_LOAD,   '{x: 16'sd0, y: ONE_Q, z: 16'sd0, w: 16'sd0});
    offer_request(OP_ROTATE, '{x: 16'sd0, y: 16'sd0, z: ONE_Q, w: 16'sd0});
    offer_request(OP_LOAD,   '{x: 16'sd0, y: 16'sd0, z: 16'sd0, w: ONE_Q});
    offer_request(OP_ROTATE, '{x: 16'sd8192, y: -16'sd8192, z: 16'sd8192, w: 16'sd8192});
    wait_for_matrices();

    // Random phases: no idling, sender idle, receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 53 : (phase == 3) ? 22 : 0;
      rx_stall_pct <= (phase == 2) ? 53 : (phase == 3) ? 22 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Fill the block against a stalled receiver once
        if (phase == 0 && n == 40) hold_asked <= hold_asked + 1;
        if (n == RANDOM_PER_PHASE / 2) wait_for_matrices();
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          op = OP_ROTATE;
          q  = near_unit_quat();
        end else if (pick < 65) begin
          op = OP_LOAD;
          q  = near_unit_quat();
        end else if (pick < 80) begin
          op = OP_LOAD;
          q  = '{x: comp_t'($urandom), y: comp_t'($urandom),
                 z: comp_t'($urandom), w: comp_t'($urandom)};
        end else if (pick < 92) begin
          op = OP_ROTATE;
          q  = '{x: comp_t'($urandom), y: comp_t'($urandom),
                 z: comp_t'($urandom), w: comp_t'($urandom)};
        end else begin
          op = op_t'($urandom_range(0, 1));
          q  = '{x: corners[$urandom_range(0, 4)], y: corners[$urandom_range(0, 4)],
                 z: corners[$urandom_range(0, 4)], w: corners[$urandom_range(0, 4)]};
        end
        offer_request(op, q);
      end
      wait_for_matrices();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
